// ===== hdl/rcsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcsd_pkg
// Shared constants, control word type and microprogram of the RC servo
// frame decoder.
// ----------------------------------------------------------------------------
package rcsd_pkg;

  localparam int unsigned MaxChannels = 8;
  localparam int unsigned StoreDepth  = MaxChannels * 2 + 5;
  localparam int unsigned AddrW       = $clog2(StoreDepth);
  localparam int unsigned ChanW       = 3;
  localparam int unsigned NumW        = $clog2(MaxChannels + 1);
  localparam int unsigned IdxW        = 10;
  localparam int unsigned ValW        = 13;

  localparam logic [7:0] SyncByte = 8'hA8;

  localparam int unsigned InLow     = 1000;
  localparam int unsigned InSpan    = 1000;
  localparam int unsigned OutLow    = 4320;
  localparam int unsigned OutSpan   = 220;
  localparam int unsigned RatioGcd  = 20;
  localparam int unsigned MulFactor = OutSpan / RatioGcd;
  localparam int unsigned DivFactor = InSpan / RatioGcd;
  localparam int unsigned RecipSh   = 22;
  localparam int unsigned Recip     = ((1 << RecipSh) + DivFactor - 1) / DivFactor;
  localparam int unsigned MagW      = 17;
  localparam int unsigned ProdW     = 2 * MagW;
  localparam int unsigned QuotW     = 11;

  typedef logic [2:0] step_t;
  typedef logic [1:0] cond_t;

  localparam step_t StepIdle = 3'd0;
  localparam step_t StepRdHi = 3'd1;
  localparam step_t StepRdLo = 3'd2;
  localparam step_t StepCalc = 3'd3;
  localparam step_t StepMul  = 3'd4;
  localparam step_t StepOut  = 3'd5;

  localparam cond_t CondSeq   = 2'd0;
  localparam cond_t CondFrame = 2'd1;
  localparam cond_t CondEmit  = 2'd2;

  typedef struct packed {
    logic  accept;
    logic  rd_lo;
    logic  ld_hi;
    logic  ld_mag;
    logic  ld_prod;
    logic  ld_out;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic frame_end;
    logic out_blocked;
    logic more;
  } seq_flags_t;

  function automatic ctrl_t prog_word(step_t step);
    ctrl_t w;
    w = '0;
    w.cond   = CondSeq;
    w.target = StepIdle;
    case (step)
      StepIdle: begin
        w.accept = 1'b1;
        w.cond   = CondFrame;
        w.target = StepRdHi;
      end
      StepRdHi: begin
        w.cond = CondSeq;
      end
      StepRdLo: begin
        w.rd_lo = 1'b1;
        w.ld_hi = 1'b1;
      end
      StepCalc: begin
        w.ld_mag = 1'b1;
      end
      StepMul: begin
        w.ld_prod = 1'b1;
      end
      StepOut: begin
        w.ld_out = 1'b1;
        w.cond   = CondEmit;
        w.target = StepRdHi;
      end
      default: begin
        w.cond   = CondFrame;
        w.target = StepIdle;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/rc_servo_frame_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// rc_servo_frame_decoder_unit
// Decodes framed RC servo data from a received byte stream into scaled
// pulse compare values, one transaction per channel.
// ----------------------------------------------------------------------------
// Input channel: one received byte per transaction (rx_byte_i). While idle,
// bytes other than the sync value are dropped. A sync byte opens a frame;
// byte 2 gives the channel count N and the frame closes after 2N+5 bytes.
// Bytes may follow back to back; in_ready_o is high whenever no frame is decoding.
// Output channel: when a frame closes, min(N,8) transactions follow in
// channel order, last_o marking the final one; a count of zero gives none.
// Each channel passes through the shared scaler (store read of two
// bytes, offset and scale, reciprocal multiply, output load), and a full
// frame drains all 8 channels before input opens again.
// A stalled receiver holds the output register and the sequencer; the
// last channel of a frame may still wait while new bytes are taken.
// Reset returns the block to sync hunting with no result pending; it
// needs no clearing pass.
// ----------------------------------------------------------------------------
module rc_servo_frame_decoder_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 rx_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rcsd_pkg::ChanW-1:0] channel_o,
  output logic [rcsd_pkg::ValW-1:0]  pulse_value_o,
  output logic                       last_o
);
  import rcsd_pkg::*;

  ctrl_t      ctrl;
  seq_flags_t flags;

  logic [7:0] store_mem [StoreDepth];
  logic [7:0] rd_q;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic       wr_en;

  logic            in_frame_q;
  logic [IdxW-1:0] idx_q, idx_next, frame_len;
  logic [7:0]      count_q, count_eff;
  logic [NumW-1:0] num_q, num_eff;
  logic [ChanW-1:0] chan_q;
  logic            accept, frame_close;

  logic [7:0]         hi_q;
  logic [15:0]        word;
  logic signed [13:0] diff;
  logic [12:0]        mag_abs;
  logic [MagW-1:0]    mag_q;
  logic               neg_q, neg_p_q;
  logic [ProdW-1:0]   prod_q;
  logic [QuotW-1:0]   quot;
  logic [ValW-1:0]    val;

  logic             out_valid_q;
  logic [ChanW-1:0] out_chan_q;
  logic [ValW-1:0]  out_val_q;
  logic             out_last_q;
  logic             out_load, more;

  rcsd_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flags_i(flags),
    .ctrl_o (ctrl)
  );

  assign in_ready_o = ctrl.accept;
  assign accept     = in_valid_i && ctrl.accept;

  assign count_eff = (idx_q == IdxW'(2)) ? rx_byte_i : count_q;
  assign idx_next  = idx_q + IdxW'(1);
  assign frame_len = IdxW'({count_eff, 1'b0}) + IdxW'(5);
  assign num_eff   = (count_eff > 8'(MaxChannels)) ? NumW'(MaxChannels) : NumW'(count_eff);
  assign frame_close = accept && in_frame_q && (idx_next == frame_len);

  assign more = (NumW'(chan_q) + NumW'(1)) != num_q;

  assign flags.frame_end   = frame_close && (num_eff != '0);
  assign flags.out_blocked = out_valid_q && !out_ready_i;
  assign flags.more        = more;

  assign out_load = ctrl.ld_out && !flags.out_blocked;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      idx_q      <= '0;
      count_q    <= 8'd1;
      num_q      <= '0;
      chan_q     <= '0;
    end else begin
      if (accept) begin
        if (!in_frame_q) begin
          if (rx_byte_i == SyncByte) begin
            in_frame_q <= 1'b1;
            idx_q      <= IdxW'(1);
            count_q    <= 8'd1;
          end
        end else if (frame_close) begin
          in_frame_q <= 1'b0;
          idx_q      <= '0;
          count_q    <= count_eff;
          num_q      <= num_eff;
          chan_q     <= '0;
        end else begin
          idx_q   <= idx_next;
          count_q <= count_eff;
        end
      end
      if (out_load) begin
        chan_q <= chan_q + ChanW'(1);
      end
    end
  end

  assign wr_en   = accept && (in_frame_q ? (idx_q < IdxW'(StoreDepth))
                                         : (rx_byte_i == SyncByte));
  assign wr_addr = in_frame_q ? idx_q[AddrW-1:0] : '0;
  assign rd_addr = AddrW'({chan_q, 1'b0}) + (ctrl.rd_lo ? AddrW'(4) : AddrW'(3));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= rx_byte_i;
    end
    rd_q <= store_mem[rd_addr];
  end

  assign word    = {hi_q, rd_q};
  assign diff    = $signed({1'b0, word[15:3]}) - $signed(14'(InLow));
  assign mag_abs = diff[13] ? 13'(-diff) : 13'(diff);
  assign quot    = prod_q[RecipSh +: QuotW];
  assign val     = neg_p_q ? (ValW'(OutLow) - ValW'(quot)) : (ValW'(OutLow) + ValW'(quot));

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_hi) begin
      hi_q <= rd_q;
    end
    if (ctrl.ld_mag) begin
      mag_q <= MagW'(mag_abs) * MagW'(MulFactor);
      neg_q <= diff[13];
    end
    if (ctrl.ld_prod) begin
      prod_q  <= ProdW'(mag_q) * ProdW'(Recip);
      neg_p_q <= neg_q;
    end
    if (out_load) begin
      out_chan_q <= chan_q;
      out_val_q  <= val;
      out_last_q <= !more;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign channel_o     = out_chan_q;
  assign pulse_value_o = out_val_q;
  assign last_o        = out_last_q;

endmodule

// ===== hdl/rcsd_seq.sv =====
// ----------------------------------------------------------------------------
// rcsd_seq
// Step counter and microprogram ROM with conditional jumps.
// ----------------------------------------------------------------------------
module rcsd_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rcsd_pkg::seq_flags_t flags_i,
  output rcsd_pkg::ctrl_t     ctrl_o
);
  import rcsd_pkg::*;

  step_t step_q, step_d;
  ctrl_t ctrl;

  assign ctrl   = prog_word(step_q);
  assign ctrl_o = ctrl;

  always_comb begin
    step_d = step_q;
    case (ctrl.cond)
      CondSeq:   step_d = step_q + step_t'(1);
      CondFrame: step_d = flags_i.frame_end ? ctrl.target : step_q;
      CondEmit: begin
        if (!flags_i.out_blocked) begin
          step_d = flags_i.more ? ctrl.target : StepIdle;
        end
      end
      default:   step_d = StepIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepIdle;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== hdl/rcsd_chk.sv =====
// ----------------------------------------------------------------------------
// rcsd_chk
// Port-level checks of the RC servo frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rcsd_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [rcsd_pkg::ChanW-1:0] channel_o,
  input logic [rcsd_pkg::ValW-1:0]  pulse_value_o,
  input logic                       last_o
);
  import rcsd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(channel_o)
      && $stable(pulse_value_o) && $stable(last_o))
    else $error("output transaction changed while stalled");

  a_val_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pulse_value_o >= ValW'(4100)) && (pulse_value_o <= ValW'(5902)))
    else $error("pulse value out of range");

  a_idle_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_ready_o |-> last_o)
    else $error("input open while a frame is still draining");

  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown({channel_o, pulse_value_o, last_o}))
    else $error("output transaction carries unknown bits");

endmodule

bind rc_servo_frame_decoder_unit rcsd_chk u_rcsd_chk (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams into rc_servo_frame_decoder_unit: noise while hunting,
// frames of every channel count class, extreme and rounding-sensitive words,
// oversized counts and random frames. It predicts each channel transaction
// from its own frame tracker and compares every field in order.
// ----------------------------------------------------------------------------
module testbench;
  import rcsd_pkg::*;

  typedef struct {
    logic [ChanW-1:0] chan;
    logic [ValW-1:0]  pulse;
    logic             last;
  } pulse_result_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic [7:0]       rx_byte_i   = 8'h00;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [ChanW-1:0] channel_o;
  logic [ValW-1:0]  pulse_value_o;
  logic             last_o;

  pulse_result_t pending_pulses[$];
  logic [15:0]   preset_words[$];
  int            mismatch_count = 0;
  bit            no_gaps = 1'b0;

  logic          frame_open = 1'b0;
  logic [9:0]    bytes_taken = '0;
  logic [7:0]    count_byte = 8'd1;
  logic [7:0]    frame_bytes [StoreDepth];

  rc_servo_frame_decoder_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .channel_o     (channel_o),
    .pulse_value_o (pulse_value_o),
    .last_o        (last_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [ValW-1:0] pulse_for_word(input logic [15:0] word);
    int x;
    int v;
    x = int'(word) >>> 3;
    v = (x - int'(InLow)) * int'(OutSpan) / int'(InSpan) + int'(OutLow);
    return v[ValW-1:0];
  endfunction

  function automatic void track_frame_byte(input logic [7:0] b);
    int unsigned   frame_len;
    int unsigned   n;
    pulse_result_t r;
    if (!frame_open) begin
      if (b == SyncByte) begin
        frame_bytes[0] = b;
        bytes_taken    = 10'd1;
        count_byte     = 8'd1;
        frame_open     = 1'b1;
      end
      return;
    end
    if (bytes_taken == 10'd2) count_byte = b;
    if (bytes_taken < StoreDepth) frame_bytes[bytes_taken] = b;
    bytes_taken = bytes_taken + 10'd1;
    frame_len = 2 * int'(count_byte) + 5;
    if (int'(bytes_taken) != frame_len) return;
    frame_open  = 1'b0;
    bytes_taken = '0;
    n = (count_byte > MaxChannels) ? MaxChannels : count_byte;
    for (int unsigned k = 0; k < n; k++) begin
      r.chan  = ChanW'(k);
      r.pulse = pulse_for_word({frame_bytes[2*k+3], frame_bytes[2*k+4]});
      r.last  = (k + 1 == n);
      pending_pulses.push_back(r);
    end
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h1F40 | 16'($urandom_range(15));
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, want %0d", what, got, want);
    mismatch_count++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (!no_gaps) begin
      while ($urandom_range(99) < 30) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    track_frame_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] status, input logic [7:0] count);
    logic [15:0] w;
    send_byte(SyncByte);
    send_byte(status);
    send_byte(count);
    for (int k = 0; k < int'(count); k++) begin
      w = (preset_words.size() != 0) ? preset_words.pop_front() : pick_word();
      send_byte(w[15:8]);
      send_byte(w[7:0]);
    end
    send_byte(8'($urandom_range(255)));
    send_byte(8'($urandom_range(255)));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_pulses.size() != 0);
  endtask

  task automatic test_idle_noise();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h57);
    send_byte(8'hA7);
  endtask

  task automatic test_zero_count();
    send_frame(8'h00, 8'd0);
  endtask

  task automatic test_pulse_extremes();
    preset_words = {16'h0000, 16'hFFFF, 16'h1F40, 16'h1F28};
    send_frame(SyncByte, 8'd4);
  endtask

  task automatic test_full_frame();
    preset_words = {16'h0000, 16'h00A8, 16'hA800, 16'hFFFF};
    send_frame(8'h01, 8'(MaxChannels));
  endtask

  task automatic test_over_count();
    send_frame(8'h81, 8'(MaxChannels + 1));
    send_frame(8'h7E, 8'd12);
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    repeat (3) send_frame(8'($urandom_range(255)), 8'(MaxChannels));
    no_gaps = 1'b0;
  endtask

  task automatic test_drain_pause();
    send_frame(8'h01, 8'd3);
    drain_results();
    send_frame(8'h01, 8'd1);
  endtask

  task automatic test_random_frames();
    int         taken;
    int         n;
    logic [7:0] noise;
    taken = 0;
    while (taken < 30) begin
      if ($urandom_range(99) < 20) begin
        noise = 8'($urandom_range(255));
        send_byte((noise == SyncByte) ? (noise ^ 8'h01) : noise);
      end else begin
        n = ($urandom_range(99) < 85) ? $urandom_range(MaxChannels)
                                      : $urandom_range(12, MaxChannels + 1);
        send_frame(8'($urandom_range(255)), 8'(n));
        taken += 2 * n + 5;
      end
    end
  endtask

  always @(posedge clk_i) begin : check_results
    pulse_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pulses.size() == 0) begin
        report_mismatch("result with nothing pending, channel", channel_o, -1);
      end else begin
        want = pending_pulses.pop_front();
        if (channel_o !== want.chan) report_mismatch("channel", channel_o, want.chan);
        if (pulse_value_o !== want.pulse) begin
          report_mismatch("pulse_value", pulse_value_o, want.pulse);
        end
        if (last_o !== want.last) report_mismatch("last", last_o, want.last);
      end
    end
    out_ready_i <= no_gaps || ($urandom_range(99) >= 30);
  end

  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_noise();
    test_zero_count();
    test_pulse_extremes();
    test_full_frame();
    test_over_count();
    test_back_to_back();
    test_drain_pause();
    test_random_frames();
    drain_results();
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0 && pending_pulses.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== rc_servo_frame_decoder_unit.f =====
hdl/rcsd_pkg.sv
hdl/rcsd_seq.sv
hdl/rc_servo_frame_decoder_unit.sv
hdl/rcsd_chk.sv
tb/testbench.sv
